FILE: rtl/core/mwo_pkg.sv
// Shared constants, types and the quarter-wave sine table builder for the oscillator.
package mwo_pkg;

  localparam int PHASE_BITS  = 32;
  localparam int SAMPLE_BITS = 16;
  localparam int TABLE_BITS  = 10;
  localparam int STEP_BITS   = 32;
  localparam int MODE_BITS   = 2;

  localparam int QUAD_BITS  = PHASE_BITS - 2;
  localparam int TAB_N      = 1 << TABLE_BITS;
  localparam int ADDR_BITS  = TABLE_BITS + 1;
  localparam int MAG_BITS   = SAMPLE_BITS - 1;
  localparam int FULL_SCALE = (1 << (SAMPLE_BITS - 1)) - 1;
  localparam int TRI_CUT    = (QUAD_BITS > 36) ? (QUAD_BITS - 36) : 0;
  localparam int TRI_BITS   = QUAD_BITS - TRI_CUT;
  localparam int SAW_CUT    = (PHASE_BITS > 38) ? (PHASE_BITS - 38) : 0;
  localparam int SAW_BITS   = PHASE_BITS - SAW_CUT;

  localparam logic [63:0] HALF_PI_Q30 = 64'h6487ED51;
  localparam logic [63:0] ONE_Q30     = 64'd1 << 30;

  typedef enum logic [MODE_BITS-1:0] {
    MODE_SINE     = 2'd0,
    MODE_SQUARE   = 2'd1,
    MODE_TRIANGLE = 2'd2,
    MODE_SAWTOOTH = 2'd3
  } mode_e;

  typedef logic [MAG_BITS-1:0] sine_word_t;
  typedef sine_word_t sine_tab_t [TAB_N+1];

  // Metadata that rides alongside the table read into the shaping stage.
  typedef struct packed {
    mode_e                  mode;
    logic [1:0]             quad;
    logic [MAG_BITS-1:0]    tri_mag;
    logic [SAMPLE_BITS-1:0] saw_raw;
  } shape_meta_t;

  // Shift-subtract quotient, evaluated only while the table is built.
  function automatic logic [63:0] div_u64(logic [63:0] num, logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] part;
    quo  = '0;
    part = '0;
    for (int i = 63; i >= 0; i--) begin
      part = {part[63:0], num[i]};
      if (part >= {1'b0, den}) begin
        part   = part - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // One entry: Taylor series of sin in Q30, terms up to x^15, clamped to [0, 1].
  function automatic sine_word_t sine_entry(int k);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic [63:0]        dv;
    logic [63:0]        scaled;
    logic signed [63:0] sum;
    x    = ((64'(k) * HALF_PI_Q30) + 64'(TAB_N / 2)) >> TABLE_BITS;
    x2   = (x * x) >> 30;
    term = x;
    sum  = '0;
    for (int n = 1; n <= 8; n++) begin
      if (n[0]) begin
        sum = sum + $signed(term);
      end else begin
        sum = sum - $signed(term);
      end
      dv   = 64'((2 * n) * (2 * n + 1));
      term = div_u64((term * x2) >> 30, dv);
    end
    if (sum < 0) begin
      sum = '0;
    end
    if (sum > $signed(ONE_Q30)) begin
      sum = $signed(ONE_Q30);
    end
    scaled = (($unsigned(sum) * 64'(FULL_SCALE)) + (64'd1 << 29)) >> 30;
    return scaled[MAG_BITS-1:0];
  endfunction

  function automatic sine_tab_t build_sine_tab();
    sine_tab_t tab;
    for (int k = 0; k <= TAB_N; k++) begin
      tab[k] = sine_entry(k);
    end
    return tab;
  endfunction

endpackage

FILE: rtl/core/mwo_sine_rom.sv
// Quarter-wave sine ROM with a registered read port.
module mwo_sine_rom (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [mwo_pkg::ADDR_BITS-1:0] addr_i,
  output logic [mwo_pkg::MAG_BITS-1:0]  data_o
);
  import mwo_pkg::*;

  localparam sine_tab_t SineTab = build_sine_tab();

  logic [MAG_BITS-1:0] data_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= SineTab[addr_i];
    end
  end

  assign data_o = data_q;

endmodule

FILE: rtl/core/mwo_wave_shaper.sv
// Final waveform selection: sign, mirror and offset of table and ramp values.
module mwo_wave_shaper (
  input  mwo_pkg::shape_meta_t                meta_i,
  input  logic [mwo_pkg::MAG_BITS-1:0]        sine_mag_i,
  output logic signed [mwo_pkg::SAMPLE_BITS-1:0] sample_o
);
  import mwo_pkg::*;

  localparam logic signed [SAMPLE_BITS-1:0] Fs = SAMPLE_BITS'(FULL_SCALE);

  logic signed [SAMPLE_BITS-1:0] sine_v;
  logic signed [SAMPLE_BITS-1:0] tri_m;
  logic signed [SAMPLE_BITS-1:0] tri_v;

  always_comb begin
    sine_v = $signed({1'b0, sine_mag_i});
    if (meta_i.quad[1]) begin
      sine_v = -sine_v;
    end
    tri_m = $signed({1'b0, meta_i.tri_mag});
    case (meta_i.quad)
      2'd0:    tri_v = tri_m;
      2'd1:    tri_v = Fs - tri_m;
      2'd2:    tri_v = -tri_m;
      default: tri_v = tri_m - Fs;
    endcase
  end

  always_comb begin
    unique case (meta_i.mode)
      MODE_SINE:     sample_o = sine_v;
      // zero at phase 0 and half cycle gives the negative level
      MODE_SQUARE:   sample_o = ((sine_mag_i != '0) && !meta_i.quad[1]) ? Fs : -Fs;
      MODE_TRIANGLE: sample_o = tri_v;
      MODE_SAWTOOTH: sample_o = $signed(meta_i.saw_raw) - Fs;
      default:       sample_o = sine_v;
    endcase
  end

endmodule

FILE: rtl/core/multi_waveform_phase_oscillator_top.sv
// Top level of the phase-accumulator oscillator: handshake, phase, table address and ramps.
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one sample tick per transfer: a
//   waveform mode (sine, square, triangle, sawtooth) and a 32-bit phase step.
//   Output channel (out_valid_o/out_ready_i) returns one signed Q1.15 sample per
//   input transfer, in order.
//   Each sample is taken at the phase before that tick's step is added.
//   The input transfer edge does the registered sine ROM read; out_valid_o rises
//   when the output register is loaded with the shaped sample from that read, which
//   waits while the output register still holds an untaken sample.
//   Throughput: one sample per cycle unless out_ready_i stalls; one sine ROM read per cycle.
//   Reset clears the phase to zero and empties the pipeline; the sine table is
//   a constant ROM and needs no fill.
//   When the receiver stalls, the output register holds its sample and the ROM
//   stage can still take one more transfer; after that in_ready_o drops until the
//   output is taken.
module multi_waveform_phase_oscillator_top (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [mwo_pkg::MODE_BITS-1:0]          mode_i,
  input  logic [mwo_pkg::STEP_BITS-1:0]          phase_step_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [mwo_pkg::SAMPLE_BITS-1:0] sample_o
);
  import mwo_pkg::*;

  localparam int TriW = TRI_BITS + SAMPLE_BITS;
  localparam int SawW = SAW_BITS + SAMPLE_BITS + 1;

  logic                   in_xfer;
  logic                   adv_out;
  logic [PHASE_BITS-1:0]  phase_q, phase_d;
  logic                   s1_valid_q, s1_valid_d;
  shape_meta_t            s1_meta_q, s1_meta_d;
  logic                   out_valid_q, out_valid_d;
  logic signed [SAMPLE_BITS-1:0] sample_q, sample_d;

  logic [1:0]             quad;
  logic [QUAD_BITS-1:0]   rem;
  logic [ADDR_BITS-1:0]   idx;
  logic [ADDR_BITS-1:0]   rom_addr;
  logic [MAG_BITS-1:0]    rom_data;
  logic [TRI_BITS-1:0]    tri_rr;
  logic [TriW-1:0]        tri_prod;
  logic [SAW_BITS-1:0]    saw_ps;
  logic [SawW-1:0]        saw_prod;

  assign adv_out    = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || adv_out;
  assign in_xfer    = in_valid_i && in_ready_o;

  // Address and ramp terms from the current phase
  always_comb begin
    quad     = phase_q[PHASE_BITS-1 -: 2];
    rem      = phase_q[QUAD_BITS-1:0];
    idx      = {1'b0, rem[QUAD_BITS-1 -: TABLE_BITS]};
    rom_addr = quad[0] ? (ADDR_BITS'(TAB_N) - idx) : idx;
    tri_rr   = rem[QUAD_BITS-1 -: TRI_BITS];
    tri_prod = (TriW'(tri_rr) * TriW'(FULL_SCALE))
             + TriW'({1'b1, {(TRI_BITS-1){1'b0}}});
    saw_ps   = phase_q[PHASE_BITS-1 -: SAW_BITS];
    saw_prod = (SawW'(saw_ps) * SawW'(2 * FULL_SCALE))
             + SawW'({1'b1, {(SAW_BITS-1){1'b0}}});

    s1_meta_d.mode    = mode_e'(mode_i);
    s1_meta_d.quad    = quad;
    s1_meta_d.tri_mag = tri_prod[TRI_BITS +: MAG_BITS];
    s1_meta_d.saw_raw = saw_prod[SAW_BITS +: SAMPLE_BITS];
  end

  always_comb begin
    phase_d     = phase_q;
    s1_valid_d  = s1_valid_q;
    out_valid_d = out_valid_q;
    if (in_xfer) begin
      phase_d = phase_q + PHASE_BITS'(phase_step_i);
    end
    if (in_ready_o) begin
      s1_valid_d = in_xfer;
    end
    if (adv_out) begin
      out_valid_d = s1_valid_q;
    end
  end

  mwo_sine_rom u_rom (
    .clk_i  (clk_i),
    .en_i   (in_ready_o),
    .addr_i (rom_addr),
    .data_o (rom_data)
  );

  mwo_wave_shaper u_shaper (
    .meta_i     (s1_meta_q),
    .sine_mag_i (rom_data),
    .sample_o   (sample_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o) begin
      s1_meta_q <= s1_meta_d;
    end
    if (adv_out && s1_valid_q) begin
      sample_q <= sample_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign sample_o    = sample_q;

endmodule
